/* design/jpst_pkg.sv */
// package for the json path segment tokenizer
// holds parse modes, result kinds, character codes and the result group type
// no dependencies
package jpst_pkg;

  typedef enum logic [2:0] {
    MODE_BOUNDARY = 3'd0,
    MODE_KEY      = 3'd1,
    MODE_ESCAPE   = 3'd2,
    MODE_OFFSET   = 3'd3,
    MODE_AFTER    = 3'd4,
    MODE_DEAD     = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    KIND_BYTE   = 2'd0,
    KIND_KEYEND = 2'd1,
    KIND_OFFSET = 2'd2,
    KIND_END    = 2'd3
  } kind_t;

  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam int OUT_OFFSET_W = 32;

  // results caused by one input item, in order k0, k1, k2
  typedef struct packed {
    logic [1:0]              n;
    kind_t                   k0;
    kind_t                   k1;
    kind_t                   k2;
    logic [7:0]              b0;
    logic [7:0]              b1;
    logic [OUT_OFFSET_W-1:0] off;
    logic                    ok;
  } group_t;

endpackage

/* design/jpst_parser.sv */
// parse state and per-character decode for the json path segment tokenizer
// produces the result group of one input transfer; depends on jpst_pkg
module jpst_parser
  import jpst_pkg::*;
#(
  parameter int OFFSET_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  logic       cmd,
  input  logic [7:0] char_in,
  output group_t     grp
);

  mode_t                  mode_r, mode_nxt;
  logic [OFFSET_BITS-1:0] acc_r, acc_nxt;
  logic                   ok_r, ok_nxt;

  logic [OFFSET_BITS+3:0]  mac;
  logic                    mac_ovf;
  logic [OUT_OFFSET_W-1:0] off_clamp;
  logic                    is_digit;

  assign is_digit = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
  assign mac = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1)
             + {{OFFSET_BITS{1'b0}}, char_in[3:0]};
  assign mac_ovf = |mac[OFFSET_BITS+3:OFFSET_BITS];

  generate
    if (OFFSET_BITS > OUT_OFFSET_W) begin : g_wide
      assign off_clamp = (|acc_r[OFFSET_BITS-1:OUT_OFFSET_W]) ? '1
                       : acc_r[OUT_OFFSET_W-1:0];
    end else begin : g_narrow
      assign off_clamp = OUT_OFFSET_W'(acc_r);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_BOUNDARY;
      acc_r  <= '0;
      ok_r   <= 1'b1;
    end else if (fire) begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      ok_r   <= ok_nxt;
    end
  end

  always_comb begin
    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    ok_nxt   = ok_r;
    grp      = '0;
    grp.off  = off_clamp;
    grp.ok   = ok_r;
    if (cmd) begin
      // path end
      mode_nxt = MODE_BOUNDARY;
      acc_nxt  = '0;
      ok_nxt   = 1'b1;
      unique case (mode_r)
        MODE_KEY: begin
          grp.n  = 2'd2;
          grp.k0 = KIND_KEYEND;
          grp.k1 = KIND_END;
        end
        MODE_ESCAPE: begin
          grp.n  = 2'd3;
          grp.k0 = KIND_BYTE;
          grp.b0 = CH_BSLASH;
          grp.k1 = KIND_KEYEND;
          grp.k2 = KIND_END;
        end
        MODE_OFFSET: begin
          grp.n  = 2'd2;
          grp.k0 = KIND_OFFSET;
          grp.k1 = KIND_END;
        end
        default: begin
          grp.n  = 2'd1;
          grp.k0 = KIND_END;
        end
      endcase
    end else begin
      unique case (mode_r) inside
        MODE_BOUNDARY, MODE_KEY: begin
          if (char_in == CH_LBRACK) begin
            if (mode_r == MODE_KEY) begin
              grp.n  = 2'd1;
              grp.k0 = KIND_KEYEND;
            end
            acc_nxt  = '0;
            mode_nxt = MODE_OFFSET;
          end else if (char_in == CH_SLASH) begin
            if (mode_r == MODE_KEY) begin
              grp.n    = 2'd1;
              grp.k0   = KIND_KEYEND;
              mode_nxt = MODE_BOUNDARY;
            end else begin
              mode_nxt = MODE_KEY;
            end
          end else if (char_in == CH_BSLASH) begin
            mode_nxt = MODE_ESCAPE;
          end else begin
            grp.n    = 2'd1;
            grp.k0   = KIND_BYTE;
            grp.b0   = char_in;
            mode_nxt = MODE_KEY;
          end
        end
        MODE_ESCAPE: begin
          if (char_in == CH_LBRACK || char_in == CH_SLASH) begin
            grp.n  = 2'd1;
            grp.k0 = KIND_BYTE;
            grp.b0 = char_in;
          end else begin
            // backslash kept as a literal
            grp.n  = 2'd2;
            grp.k0 = KIND_BYTE;
            grp.b0 = CH_BSLASH;
            grp.k1 = KIND_BYTE;
            grp.b1 = char_in;
          end
          mode_nxt = MODE_KEY;
        end
        MODE_OFFSET: begin
          if (is_digit) begin
            acc_nxt = mac_ovf ? '1 : mac[OFFSET_BITS-1:0];
          end else if (char_in == CH_RBRACK) begin
            grp.n    = 2'd1;
            grp.k0   = KIND_OFFSET;
            acc_nxt  = '0;
            mode_nxt = MODE_AFTER;
          end else begin
            ok_nxt   = 1'b0;
            mode_nxt = MODE_DEAD;
          end
        end
        MODE_AFTER: begin
          if (char_in == CH_SLASH) begin
            mode_nxt = MODE_KEY;
          end else if (char_in == CH_LBRACK) begin
            acc_nxt  = '0;
            mode_nxt = MODE_OFFSET;
          end else begin
            ok_nxt   = 1'b0;
            mode_nxt = MODE_DEAD;
          end
        end
        default: begin
          mode_nxt = MODE_DEAD;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_dead_not_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_DEAD) |-> !ok_r)
    else $error("dead mode with path still valid");

  a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && cmd) |=> (mode_r == MODE_BOUNDARY && ok_r && acc_r == '0))
    else $error("path end did not restore reset state");

  a_acc_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_BOUNDARY || mode_r == MODE_KEY || mode_r == MODE_AFTER)
      |-> (acc_r == '0))
    else $error("offset accumulator nonzero outside brackets");
`endif

endmodule

/* design/jpst_out_buf.sv */
// two-group output buffer, one result of a group per cycle while out_ready is high
// the second group lets a transfer be taken while the output stalls; depends on jpst_pkg
module jpst_out_buf
  import jpst_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  group_t                  grp,
  output logic                    space,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              out_kind,
  output logic [7:0]              out_key_byte,
  output logic [OUT_OFFSET_W-1:0] out_offset_value,
  output logic                    out_path_valid,
  output logic                    out_last
);

  group_t     a_r, b_r;
  logic       a_vld_r, b_vld_r;
  logic [1:0] idx_r;
  logic       last, a_done, out_fire;
  kind_t      kind;
  logic [7:0] byte_sel;

  assign space     = !b_vld_r;
  assign out_valid = a_vld_r;
  assign last      = (idx_r == a_r.n - 2'd1);
  assign out_fire  = a_vld_r && out_ready;
  assign a_done    = out_fire && last;

  always_comb begin
    case (idx_r)
      2'd0:    begin kind = a_r.k0; byte_sel = a_r.b0; end
      2'd1:    begin kind = a_r.k1; byte_sel = a_r.b1; end
      default: begin kind = a_r.k2; byte_sel = 8'd0;   end
    endcase
  end

  assign out_kind         = kind;
  assign out_key_byte     = (kind == KIND_BYTE) ? byte_sel : 8'd0;
  assign out_offset_value = (kind == KIND_OFFSET) ? a_r.off : '0;
  assign out_path_valid   = (kind == KIND_END) ? a_r.ok : 1'b0;
  assign out_last         = last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      idx_r   <= 2'd0;
    end else if (!a_vld_r || a_done) begin
      idx_r <= 2'd0;
      if (b_vld_r) begin
        a_r     <= b_r;
        a_vld_r <= 1'b1;
        b_vld_r <= 1'b0;
      end else if (push) begin
        a_r     <= grp;
        a_vld_r <= 1'b1;
      end else begin
        a_vld_r <= 1'b0;
      end
    end else begin
      if (out_fire) begin
        idx_r <= idx_r + 2'd1;
      end
      if (push) begin
        b_r     <= grp;
        b_vld_r <= 1'b1;
      end
    end
  end

`ifndef SYNTH
  a_b_needs_a: assert property (@(posedge clk) disable iff (!rst_n)
    b_vld_r |-> a_vld_r)
    else $error("skid group held without head group");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    a_vld_r |-> (a_r.n != 2'd0 && idx_r < a_r.n))
    else $error("result index outside head group");

  a_refill: assert property (@(posedge clk) disable iff (!rst_n)
    (a_done && b_vld_r) |=> (a_vld_r && !b_vld_r && idx_r == 2'd0))
    else $error("skid group not moved to head");
`endif

endmodule

/* design/json_path_segment_tokenizer.sv */
// top level of the json path segment tokenizer
// connects jpst_parser and jpst_out_buf; depends on jpst_pkg
//
// A path arrives one character per input transfer (in_cmd 0) and is closed by an
// end transfer (in_cmd 1); key bytes, key ends, array offsets and the path end come
// out one result per cycle when out_ready is high, with out_last on the final result
// of each input. The block takes one input per cycle as long as each input causes at
// most one result and out_ready stays high; since the output port sends one result
// per cycle, an input that causes two or three results (escapes, key end with path
// end) can hold in_ready low once the two-group output buffer is full. Offsets
// accumulate in OFFSET_BITS bits, saturate and are clamped to 32 bits on the output.
module json_path_segment_tokenizer
  import jpst_pkg::*;
#(
  parameter int OFFSET_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_cmd,
  input  logic [7:0]              in_char_in,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              out_kind,
  output logic [7:0]              out_key_byte,
  output logic [OUT_OFFSET_W-1:0] out_offset_value,
  output logic                    out_path_valid,
  output logic                    out_last
);

  group_t grp;
  logic   in_fire;
  logic   space;

  assign in_ready = space;
  assign in_fire  = in_valid && space;

  jpst_parser #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (in_fire),
    .cmd     (in_cmd),
    .char_in (in_char_in),
    .grp     (grp)
  );

  jpst_out_buf u_out_buf (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (in_fire && (grp.n != 2'd0)),
    .grp              (grp),
    .space            (space),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_key_byte     (out_key_byte),
    .out_offset_value (out_offset_value),
    .out_path_valid   (out_path_valid),
    .out_last         (out_last)
  );

endmodule

/* test/jpst_checker.sv */
// checker for the json path segment tokenizer: predicts the results of every input transfer
// and compares each output transfer with the oldest prediction; depends on jpst_pkg
`timescale 1ns / 100ps
module jpst_checker
  import jpst_pkg::*;
#(
  parameter int OFFSET_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic                    in_cmd,
  input  logic [7:0]              in_char_in,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic [1:0]              out_kind,
  input  logic [7:0]              out_key_byte,
  input  logic [OUT_OFFSET_W-1:0] out_offset_value,
  input  logic                    out_path_valid,
  input  logic                    out_last,
  output int                      fail_count,
  output int                      pending
);

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  key_byte;
    logic [31:0] offset;
    logic        path_valid;
    logic        last;
  } token_t;

  localparam logic [63:0] ACC_MAX = {64{1'b1}} >> (64 - OFFSET_BITS);

  token_t      expected_tokens[$];
  token_t      step_tokens[3];
  int          step_count;
  mode_t       mode;
  logic [63:0] acc;
  logic        path_ok;

  task automatic emit(input kind_t kind, input logic [7:0] b, input logic [63:0] off,
                      input logic ok);
    token_t t;
    t.kind       = kind;
    t.key_byte   = b;
    t.offset     = (off > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : off[31:0];
    t.path_valid = ok;
    t.last       = 1'b0;
    step_tokens[step_count] = t;
    step_count++;
  endtask

  task automatic tokenize(input logic cmd, input logic [7:0] c);
    logic [63:0] d;
    step_count = 0;
    if (cmd) begin
      if (mode == MODE_KEY) begin
        emit(KIND_KEYEND, 8'h00, '0, 1'b0);
      end else if (mode == MODE_ESCAPE) begin
        emit(KIND_BYTE, CH_BSLASH, '0, 1'b0);
        emit(KIND_KEYEND, 8'h00, '0, 1'b0);
      end else if (mode == MODE_OFFSET) begin
        emit(KIND_OFFSET, 8'h00, acc, 1'b0);
      end
      emit(KIND_END, 8'h00, '0, path_ok);
      mode    = MODE_BOUNDARY;
      acc     = '0;
      path_ok = 1'b1;
    end else begin
      case (mode) inside
        MODE_BOUNDARY, MODE_KEY: begin
          if (c == CH_LBRACK) begin
            if (mode == MODE_KEY) emit(KIND_KEYEND, 8'h00, '0, 1'b0);
            acc  = '0;
            mode = MODE_OFFSET;
          end else if (c == CH_SLASH) begin
            if (mode == MODE_KEY) begin
              emit(KIND_KEYEND, 8'h00, '0, 1'b0);
              mode = MODE_BOUNDARY;
            end else begin
              mode = MODE_KEY;
            end
          end else if (c == CH_BSLASH) begin
            mode = MODE_ESCAPE;
          end else begin
            emit(KIND_BYTE, c, '0, 1'b0);
            mode = MODE_KEY;
          end
        end
        MODE_ESCAPE: begin
          if (c != CH_LBRACK && c != CH_SLASH) emit(KIND_BYTE, CH_BSLASH, '0, 1'b0);
          emit(KIND_BYTE, c, '0, 1'b0);
          mode = MODE_KEY;
        end
        MODE_OFFSET: begin
          if (c >= CH_ZERO && c <= CH_NINE) begin
            d = 64'(c - CH_ZERO);
            if (acc > (ACC_MAX - d) / 10) acc = ACC_MAX;
            else acc = acc * 10 + d;
          end else if (c == CH_RBRACK) begin
            emit(KIND_OFFSET, 8'h00, acc, 1'b0);
            acc  = '0;
            mode = MODE_AFTER;
          end else begin
            path_ok = 1'b0;
            mode    = MODE_DEAD;
          end
        end
        MODE_AFTER: begin
          if (c == CH_SLASH) begin
            mode = MODE_KEY;
          end else if (c == CH_LBRACK) begin
            acc  = '0;
            mode = MODE_OFFSET;
          end else begin
            path_ok = 1'b0;
            mode    = MODE_DEAD;
          end
        end
        default: mode = MODE_DEAD;
      endcase
    end
    for (int i = 0; i < step_count; i++) begin
      if (i == step_count - 1) step_tokens[i].last = 1'b1;
      expected_tokens.insert(expected_tokens.size(), step_tokens[i]);
    end
  endtask

  task automatic check_token();
    token_t want;
    if (expected_tokens.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%0t unexpected result transfer: kind %0d byte %h offset %0d valid %b last %b",
                 $realtime, out_kind, out_key_byte, out_offset_value, out_path_valid,
                 out_last);
      return;
    end
    want = expected_tokens.pop_front();
    if (out_kind !== want.kind || out_key_byte !== want.key_byte ||
        out_offset_value !== want.offset || out_path_valid !== want.path_valid ||
        out_last !== want.last) begin
      fail_count++;
      if (fail_count <= 10)
        $display({"%0t mismatch: expected kind %0d byte %h offset %0d valid %b last %b,",
                  " got kind %0d byte %h offset %0d valid %b last %b"},
                 $realtime, want.kind, want.key_byte, want.offset, want.path_valid,
                 want.last, out_kind, out_key_byte, out_offset_value, out_path_valid,
                 out_last);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      mode    = MODE_BOUNDARY;
      acc     = '0;
      path_ok = 1'b1;
      expected_tokens.delete();
    end else begin
      if (in_valid && in_ready) tokenize(in_cmd, in_char_in);
      if (out_valid && out_ready) check_token();
    end
    pending = expected_tokens.size();
  end

endmodule

/* test/tb_json_path_segment_tokenizer.sv */
// testbench top for the json path segment tokenizer: drives directed and random paths
// with random idling on both channels; depends on jpst_pkg, jpst_checker and the block
`timescale 1ns / 100ps
module tb_json_path_segment_tokenizer
  import jpst_pkg::*;
;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic                    in_cmd;
  logic [7:0]              in_char_in;
  logic                    out_valid;
  logic                    out_ready;
  logic [1:0]              out_kind;
  logic [7:0]              out_key_byte;
  logic [OUT_OFFSET_W-1:0] out_offset_value;
  logic                    out_path_valid;
  logic                    out_last;
  int                      fail_count;
  int                      pending;

  localparam logic [8:0] END_ITEM = 9'h100;

  logic [7:0] path_chars[$];
  int         send_burst;
  int         take_burst;

  json_path_segment_tokenizer dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_cmd(in_cmd), .in_char_in(in_char_in),
    .out_valid(out_valid), .out_ready(out_ready), .out_kind(out_kind),
    .out_key_byte(out_key_byte), .out_offset_value(out_offset_value),
    .out_path_valid(out_path_valid), .out_last(out_last)
  );

  jpst_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_cmd(in_cmd), .in_char_in(in_char_in),
    .out_valid(out_valid), .out_ready(out_ready), .out_kind(out_kind),
    .out_key_byte(out_key_byte), .out_offset_value(out_offset_value),
    .out_path_valid(out_path_valid), .out_last(out_last),
    .fail_count(fail_count), .pending(pending)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // wait cycles before a transfer, with stretches of no idling
  function automatic int draw_gap(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 11) == 0) begin
      burst = $urandom_range(8, 24);
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  // entered and left at a falling edge
  task automatic send(input logic cmd, input logic [7:0] ch);
    int gap;
    gap = draw_gap(send_burst);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_cmd     <= cmd;
    in_char_in <= ch;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic add_char(input logic [7:0] c);
    path_chars.insert(path_chars.size(), c);
  endtask

  task automatic push_key_char();
    logic [7:0] c;
    if ($urandom_range(0, 7) == 0) begin
      add_char(CH_BSLASH);
      case ($urandom_range(0, 3))
        0: add_char(CH_LBRACK);
        1: add_char(CH_SLASH);
        2: add_char(CH_BSLASH);
        default: add_char(8'($urandom_range(0, 255)));
      endcase
    end else begin
      c = 8'($urandom_range(0, 255));
      if (c == CH_LBRACK || c == CH_SLASH || c == CH_BSLASH) c = 8'h6B;
      add_char(c);
    end
  endtask

  task automatic push_offset();
    string digits;
    int    n;
    add_char(CH_LBRACK);
    case ($urandom_range(0, 9))
      0: digits = "4294967295";
      1: digits = "4294967296";
      2: digits = "99999999999";
      default: begin
        digits = "";
        n = $urandom_range(0, 3);
        if ($urandom_range(0, 9) == 0) n = $urandom_range(10, 12);
        repeat (n) digits = {digits, string'(8'(CH_ZERO + $urandom_range(0, 9)))};
      end
    endcase
    for (int i = 0; i < digits.len(); i++) add_char(digits[i]);
    add_char(CH_RBRACK);
  endtask

  task automatic build_path();
    int segs;
    int pos;
    path_chars.delete();
    segs = $urandom_range(1, 4);
    for (int s = 0; s < segs; s++) begin
      if ($urandom_range(0, 2) == 0) begin
        push_offset();
      end else begin
        if (s > 0 || $urandom_range(0, 1) == 0) add_char(CH_SLASH);
        repeat ($urandom_range(0, 4)) push_key_char();
      end
    end
    // noise and broken paths
    if (path_chars.size() > 0 && $urandom_range(0, 5) == 0) begin
      pos = $urandom_range(0, path_chars.size() - 1);
      path_chars[pos] = 8'($urandom_range(0, 255));
    end
    if (path_chars.size() > 0 && $urandom_range(0, 9) == 0) void'(path_chars.pop_back());
  endtask

  initial begin
    out_ready = 1'b0;
    take_burst = 0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      repeat (draw_gap(take_burst)) begin
        out_ready <= 1'b0;
        @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin
    logic [8:0] directed[$];
    int         items_sent;
    int         paths;
    int         guard;
    in_valid   = 1'b0;
    in_cmd     = 1'b0;
    in_char_in = 8'h00;
    rst_n      = 1'b0;
    send_burst = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    directed = '{
      // leading slash, byte extremes, empty key closed by a bracket
      {1'b0, CH_SLASH}, 9'h000, 9'h0FF, {1'b0, CH_SLASH}, {1'b0, CH_SLASH},
      {1'b0, CH_LBRACK}, {1'b0, CH_NINE}, {1'b0, CH_RBRACK}, END_ITEM,
      // backslash before plain byte, double backslash, stray byte in brackets
      {1'b0, CH_BSLASH}, 9'h071, {1'b0, CH_BSLASH}, {1'b0, CH_BSLASH},
      {1'b0, CH_LBRACK}, 9'h078, END_ITEM,
      // bad byte after closing bracket
      {1'b0, CH_LBRACK}, {1'b0, CH_RBRACK}, 9'h07A, END_ITEM,
      // bracket after bracket, unclosed bracket at end
      {1'b0, CH_LBRACK}, {1'b0, CH_RBRACK}, {1'b0, CH_LBRACK}, 9'h035, END_ITEM,
      // escaped bracket and slash, trailing backslash
      9'h061, {1'b0, CH_BSLASH}, {1'b0, CH_LBRACK}, {1'b0, CH_BSLASH}, {1'b0, CH_SLASH},
      {1'b0, CH_BSLASH}, END_ITEM
    };
    foreach (directed[i]) begin
      if (directed[i][8]) send(1'b1, 8'($urandom_range(0, 255)));
      else send(1'b0, directed[i][7:0]);
    end
    drain();

    items_sent = directed.size();
    paths      = 0;
    while (items_sent < 170) begin
      build_path();
      foreach (path_chars[i]) send(1'b0, path_chars[i]);
      send(1'b1, 8'($urandom_range(0, 255)));
      items_sent += path_chars.size() + 1;
      paths++;
      if (paths % 6 == 0) drain();
    end
    in_valid <= 1'b0;

    guard = 0;
    while (pending != 0 && guard < 20000) begin
      @(negedge clk);
      guard++;
    end
    repeat (20) @(negedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/jpst_pkg.sv
design/jpst_parser.sv
design/jpst_out_buf.sv
design/json_path_segment_tokenizer.sv
test/jpst_checker.sv
test/tb_json_path_segment_tokenizer.sv
